// ----- rtl/core/dde_pkg.sv -----
// ----------------------------------------------------------------------------
// dde_pkg
// Shared widths, constants and types of the pose estimator.
// ----------------------------------------------------------------------------
package dde_pkg;

    localparam int CW    = 34;   // CORDIC datapath width
    localparam int MUL_A = 41;   // serial multiplicand width
    localparam int MUL_B = 32;   // serial multiplier width

    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

    typedef enum logic [1:0] {
        FUNC_ODOM    = 2'd0,
        FUNC_CAMERA  = 2'd1,
        FUNC_RESTART = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        REG_DIST_PER_TICK    = 3'd0,
        REG_HEADING_PER_TICK = 3'd1,
        REG_START_X          = 3'd2,
        REG_START_Y          = 3'd3,
        REG_START_HEADING    = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic                 start;
        logic                 vectoring;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cordic_req_t;

    typedef logic [31:0] atan_tab_t [32];

    localparam atan_tab_t ATAN_TAB = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

endpackage

// ----- rtl/core/dde_serial_mul.sv -----
// ----------------------------------------------------------------------------
// dde_serial_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module dde_serial_mul
    import dde_pkg::*;
#(
    parameter int WA = 41,
    parameter int WB = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [WA-1:0]   a,
    input  logic [WB-1:0]   b,
    output logic            busy,
    output logic [WA+WB-1:0] p
);

    localparam int NW = $clog2(WB);

    logic [WA+WB-1:0] p_reg;
    logic [WA-1:0]    a_reg;
    logic [NW-1:0]    cnt_reg;
    logic             busy_reg;
    logic [WA:0]      sum;

    // partial product enters at the top, word shifts right each cycle while busy
    assign sum = {1'b0, p_reg[WA+WB-1:WB]} + (p_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == NW'(WB - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p_reg <= {{WA{1'b0}}, b};
            a_reg <= a;
        end
        else if (busy_reg)
        begin
            p_reg <= {sum, p_reg[WB-1:1]};
        end
    end

    assign busy = busy_reg;
    assign p    = p_reg;

endmodule

// ----- rtl/core/dde_cordic.sv -----
// ----------------------------------------------------------------------------
// dde_cordic
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring.
// ----------------------------------------------------------------------------
module dde_cordic
    import dde_pkg::*;
#(
    parameter int STEPS = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cordic_req_t          req,
    output logic                 busy,
    output logic signed [CW-1:0] x,
    output logic signed [CW-1:0] y,
    output logic signed [CW-1:0] z
);

    localparam int SW = $clog2(STEPS);

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic [SW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 vect_reg;
    logic signed [CW-1:0] sx, sy, at;
    logic                 dir;

    assign sx  = y_reg >>> cnt_reg;
    assign sy  = x_reg >>> cnt_reg;
    assign at  = CW'(ATAN_TAB[5'(cnt_reg)]);
    assign dir = vect_reg ? y_reg[CW-1] : !z_reg[CW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == SW'(STEPS - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg    <= req.x;
            y_reg    <= req.y;
            z_reg    <= req.z;
            vect_reg <= req.vectoring;
        end
        else if (busy_reg)
        begin
            if (dir)
            begin
                x_reg <= x_reg - sx;
                y_reg <= y_reg + sy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + sx;
                y_reg <= y_reg - sy;
                z_reg <= z_reg + at;
            end
        end
    end

    assign busy = busy_reg;
    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;

endmodule

// ----- rtl/core/diff_drive_pose_estimator.sv -----
// ----------------------------------------------------------------------------
// diff_drive_pose_estimator
// Differential-drive pose tracker: odometry, camera fix and restart.
// ----------------------------------------------------------------------------
// One item is worked on at a time and yields one pose transfer. An odometry
// item runs the iterative sin/cos unit, then the bit-serial multipliers that
// scale the travel (run side by side for x and y), then rounding and the
// saturating add. A camera fix runs the CORDIC in vectoring mode (atan2); a
// restart or a degenerate fix skips the arithmetic. A finished pose waits in
// the output register while the next item is accepted.
module diff_drive_pose_estimator
    import dde_pkg::*;
#(
    parameter int CORDIC_STEPS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // ticks_right, ticks_left, center_x, center_y,
                                    // front_x, front_y
    input  logic [1:0]   s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // pose_x, pose_y, pose_heading
    output logic [0:0]   m_tuser,   // degenerate
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORD,
        ST_MUL,
        ST_RND,
        ST_SUM,
        ST_FIN
    } state_t;

    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    state_t state_reg;

    logic [31:0] dist_per_tick_reg, heading_per_tick_reg, start_heading_reg;
    logic [47:0] start_x_reg, start_y_reg;
    logic [47:0] cur_x_reg, cur_y_reg;
    logic [31:0] cur_heading_reg;
    logic [47:0] nx_reg, ny_reg;
    logic [31:0] nh_reg;
    logic        degen_reg;
    func_t       func_reg;
    logic [MUL_A-1:0] travel_reg;
    logic        flip_reg;
    logic [31:0] base_reg;
    logic        c_neg_reg, s_neg_reg;
    logic [41:0] magx_reg, magy_reg;
    logic        m_tvalid_reg;
    logic [127:0] m_tdata_reg;
    logic        m_degen_reg;

    logic        accept;
    func_t       in_func;
    logic [7:0]  tr, tl;
    logic [15:0] cx, cy, fx, fy;
    logic signed [16:0] dx17, dy17;
    logic signed [CW-1:0] vx, vy;
    logic        in_flip;
    logic [31:0] rot_a;
    cordic_req_t creq;
    logic        cord_busy;
    logic signed [CW-1:0] cord_x, cord_y, cord_z;
    logic [CW-1:0] abs_x, abs_y;
    logic        mul_xy_start, mh_start;
    logic        mx_busy, my_busy, mh_busy;
    logic [MUL_A+MUL_B-1:0] px, py, ph;
    logic [MUL_A+MUL_B-1:0] rx, ry;
    logic        out_load;

    assign in_func = func_t'(s_tuser);
    assign tr = s_tdata[7:0];
    assign tl = s_tdata[15:8];
    assign cx = s_tdata[31:16];
    assign cy = s_tdata[47:32];
    assign fx = s_tdata[63:48];
    assign fy = s_tdata[79:64];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign dx17 = $signed({1'b0, fx}) - $signed({1'b0, cx});
    assign dy17 = $signed({1'b0, fy}) - $signed({1'b0, cy});
    // vectoring starts in the right half-plane, inputs scaled by 2^14
    assign vx = (dx17[16] ? -CW'(dx17) : CW'(dx17)) <<< 14;
    assign vy = (dx17[16] ? -CW'(dy17) : CW'(dy17)) <<< 14;

    // second and third quadrants are turned by half a turn
    assign in_flip = (cur_heading_reg[31:30] == 2'b01) || (cur_heading_reg[31:30] == 2'b10);
    assign rot_a   = in_flip ? cur_heading_reg - HALF_TURN : cur_heading_reg;

    always_comb
    begin
        creq           = '0;
        creq.vectoring = (in_func == FUNC_CAMERA);
        creq.x         = GAIN_Q30;
        creq.y         = '0;
        creq.z         = CW'($signed(rot_a));
        if (in_func == FUNC_CAMERA)
        begin
            creq.x = vx;
            creq.y = vy;
            creq.z = '0;
        end
        creq.start = accept && ((in_func == FUNC_ODOM) ||
                     ((in_func == FUNC_CAMERA) && ((dx17 != 17'sd0) || (dy17 != 17'sd0))));
    end

    dde_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (creq),
        .busy (cord_busy),
        .x    (cord_x),
        .y    (cord_y),
        .z    (cord_z)
    );

    assign abs_x = cord_x[CW-1] ? CW'(-cord_x) : CW'(cord_x);
    assign abs_y = cord_y[CW-1] ? CW'(-cord_y) : CW'(cord_y);

    assign mul_xy_start = (state_reg == ST_CORD) && !cord_busy && (func_reg == FUNC_ODOM);
    assign mh_start     = accept && (in_func == FUNC_ODOM);

    dde_serial_mul #(
        .WA(MUL_A),
        .WB(MUL_B)
    ) u_mul_x (
        .clk  (clk),
        .rst_n(rst_n),
        .start(mul_xy_start),
        .a    (travel_reg),
        .b    (abs_x[MUL_B-1:0]),
        .busy (mx_busy),
        .p    (px)
    );

    dde_serial_mul #(
        .WA(MUL_A),
        .WB(MUL_B)
    ) u_mul_y (
        .clk  (clk),
        .rst_n(rst_n),
        .start(mul_xy_start),
        .a    (travel_reg),
        .b    (abs_y[MUL_B-1:0]),
        .busy (my_busy),
        .p    (py)
    );

    // heading step: low 32 bits of (tr - tl) * heading_per_tick
    dde_serial_mul #(
        .WA(MUL_A),
        .WB(MUL_B)
    ) u_mul_h (
        .clk  (clk),
        .rst_n(rst_n),
        .start(mh_start),
        .a    (MUL_A'(heading_per_tick_reg)),
        .b    (32'(tr) - 32'(tl)),
        .busy (mh_busy),
        .p    (ph)
    );

    // round to nearest, ties away from zero, on the magnitude
    assign rx = px + (MUL_A+MUL_B)'(1 << 30);
    assign ry = py + (MUL_A+MUL_B)'(1 << 30);

    function automatic logic [47:0] sat_add(input logic [47:0] cur, input logic [41:0] mag,
                                            input logic neg);
        logic [49:0] d;
        logic [49:0] s;
        begin
            d = neg ? -{8'd0, mag} : {8'd0, mag};
            s = {{2{cur[47]}}, cur} + d;
            if (s[49:47] == 3'b000 || s[49:47] == 3'b111)
                sat_add = s[47:0];
            else if (s[49])
                sat_add = 48'h8000_0000_0000;
            else
                sat_add = 48'h7FFF_FFFF_FFFF;
        end
    endfunction

    assign out_load = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            dist_per_tick_reg    <= 32'd21082;
            heading_per_tick_reg <= 32'd15551718;
            start_x_reg          <= '0;
            start_y_reg          <= '0;
            start_heading_reg    <= '0;
            cur_x_reg            <= '0;
            cur_y_reg            <= '0;
            cur_heading_reg      <= '0;
            m_tvalid_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_DIST_PER_TICK:    dist_per_tick_reg    <= cfg_data[31:0];
                    REG_HEADING_PER_TICK: heading_per_tick_reg <= cfg_data[31:0];
                    REG_START_X:          start_x_reg          <= cfg_data;
                    REG_START_Y:          start_y_reg          <= cfg_data;
                    REG_START_HEADING:    start_heading_reg    <= cfg_data[31:0];
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready && !out_load)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (in_func)
                            FUNC_ODOM:    state_reg <= ST_CORD;
                            FUNC_CAMERA:  state_reg <= creq.start ? ST_CORD : ST_FIN;
                            default:      state_reg <= ST_FIN;
                        endcase
                    end
                end
                ST_CORD:
                begin
                    if (!cord_busy)
                        state_reg <= (func_reg == FUNC_ODOM) ? ST_MUL : ST_FIN;
                end
                ST_MUL:
                begin
                    if (!mx_busy && !my_busy && !mh_busy)
                        state_reg <= ST_RND;
                end
                ST_RND:
                    state_reg <= ST_SUM;
                ST_SUM:
                    state_reg <= ST_FIN;
                ST_FIN:
                begin
                    if (out_load)
                    begin
                        state_reg       <= ST_IDLE;
                        m_tvalid_reg    <= 1'b1;
                        cur_x_reg       <= nx_reg;
                        cur_y_reg       <= ny_reg;
                        cur_heading_reg <= nh_reg;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= in_func;
            degen_reg  <= (in_func == FUNC_CAMERA) && !creq.start;
            flip_reg   <= in_flip;
            base_reg   <= dx17[16] ? HALF_TURN : 32'd0;
            travel_reg <= MUL_A'(9'(tr) + 9'(tl)) * MUL_A'(dist_per_tick_reg);
            case (in_func)
                FUNC_CAMERA:
                begin
                    nx_reg <= {8'd0, cx, 24'd0};
                    ny_reg <= {8'd0, cy, 24'd0};
                    nh_reg <= '0;
                end
                FUNC_RESTART:
                begin
                    nx_reg <= start_x_reg;
                    ny_reg <= start_y_reg;
                    nh_reg <= start_heading_reg;
                end
                default:
                begin
                    nx_reg <= cur_x_reg;
                    ny_reg <= cur_y_reg;
                    nh_reg <= cur_heading_reg;
                end
            endcase
        end

        if (state_reg == ST_CORD && !cord_busy)
        begin
            c_neg_reg <= cord_x[CW-1] ^ flip_reg;
            s_neg_reg <= cord_y[CW-1] ^ flip_reg;
            if (func_reg == FUNC_CAMERA)
                nh_reg <= base_reg + cord_z[31:0];
        end

        if (state_reg == ST_RND)
        begin
            magx_reg <= rx[MUL_A+MUL_B-1:31];
            magy_reg <= ry[MUL_A+MUL_B-1:31];
            nh_reg   <= cur_heading_reg + ph[31:0];
        end

        if (state_reg == ST_SUM)
        begin
            nx_reg <= sat_add(cur_x_reg, magx_reg, c_neg_reg);
            ny_reg <= sat_add(cur_y_reg, magy_reg, s_neg_reg);
        end

        if (out_load)
        begin
            m_tdata_reg <= {nh_reg, ny_reg, nx_reg};
            m_degen_reg <= degen_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_degen_reg;

    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!cord_busy && !mx_busy && !my_busy && !mh_busy))
        else $error("arithmetic unit busy while accepting");

    a_round_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RND) |-> (!mx_busy && !my_busy && !mh_busy))
        else $error("rounding before multiply finished");

    a_degen_heading: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[127:96] == 32'd0))
        else $error("degenerate fix with nonzero heading");

endmodule
